// ===== rtl/ssas_pkg.sv =====
// ----------------------------------------------------------------------------
// ssas_pkg
// Types, widths and calibration constants of the sun sensor angle solver.
// ----------------------------------------------------------------------------
package ssas_pkg;

  typedef struct packed {
    logic [1:0]         sensor_index;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } in_t;

  typedef struct packed {
    logic signed [14:0] elevation;
    logic [15:0]        azimuth;
    logic               sun_seen;
    logic [1:0]         display_class;
  } out_t;

  // configuration register indexes
  localparam logic [1:0] REG_SUN_SEEN_LIMIT = 2'd0;
  localparam logic [1:0] REG_EL_BAND_LOW    = 2'd1;
  localparam logic [1:0] REG_EL_BAND_HIGH   = 2'd2;

  // display classes
  localparam logic [1:0] CLASS_NO_SUN   = 2'd0;
  localparam logic [1:0] CLASS_IN_BAND  = 2'd1;
  localparam logic [1:0] CLASS_OUT_BAND = 2'd2;

  // datapath widths
  localparam int CW     = 25;  // cordic x/y
  localparam int ZW     = 25;  // cordic angle, 1/32768 degree
  localparam int RAD_W  = 46;  // radicand of the square root
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  localparam logic signed [ZW-1:0] DEG180_FINE = 25'sd5898240;
  localparam logic signed [17:0]   DEG360_OUT  = 18'sd46080;
  localparam logic signed [16:0]   EL_LIMIT    = 17'sd11520;

  // per-sensor calibration, q.16
  localparam logic signed [19:0] GAIN_X [4] = '{20'sd329567, 20'sd317948, 20'sd331606,
                                                20'sd329567};
  localparam logic signed [19:0] GAIN_Y [4] = '{20'sd327680, 20'sd327680, 20'sd327680,
                                                20'sd327680};
  localparam logic signed [16:0] OFFS_X [4] = '{17'sd5243, -17'sd21588, 17'sd3631,
                                                -17'sd15580};
  localparam logic signed [16:0] OFFS_Y [4] = '{-17'sd10302, -17'sd11454, -17'sd5543,
                                                -17'sd33001};
  localparam logic signed [15:0] TILT_COS [4] = '{16'sd25502, 16'sd24868, 16'sd25396,
                                                  16'sd25607};
  localparam logic signed [16:0] TILT_SIN [4] = '{17'sd60371, 17'sd60635, 17'sd60415,
                                                  17'sd60326};
  localparam logic signed [41:0] SEP_SIN [4] = '{42'sd242771 * 42'sd60371,
                                                 42'sd237147 * 42'sd60635,
                                                 42'sd230164 * 42'sd60415,
                                                 42'sd232945 * 42'sd60326};
  localparam logic signed [41:0] SEP_COS [4] = '{42'sd242771 * 42'sd25502,
                                                 42'sd237147 * 42'sd24868,
                                                 42'sd230164 * 42'sd25396,
                                                 42'sd232945 * 42'sd25607};
  localparam logic signed [17:0] MOUNT_AZ [4] = '{18'sd5760, -18'sd5760, -18'sd17280,
                                                  18'sd17280};

  // atan(2^-i) in 1/32768 degree
  function automatic logic signed [ZW-1:0] atan_fine(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 25'sd1474560;
      1:  a = 25'sd870484;
      2:  a = 25'sd459940;
      3:  a = 25'sd233473;
      4:  a = 25'sd117189;
      5:  a = 25'sd58652;
      6:  a = 25'sd29333;
      7:  a = 25'sd14667;
      8:  a = 25'sd7334;
      9:  a = 25'sd3667;
      10: a = 25'sd1833;
      11: a = 25'sd917;
      12: a = 25'sd458;
      13: a = 25'sd229;
      14: a = 25'sd115;
      15: a = 25'sd57;
      16: a = 25'sd29;
      17: a = 25'sd14;
      18: a = 25'sd7;
      19: a = 25'sd4;
      20: a = 25'sd2;
      21: a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/ssas_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ssas_cordic_cell
// One vectoring step of the cordic chain with a registered output.
// ----------------------------------------------------------------------------
module ssas_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid_in,
  input  logic signed [ssas_pkg::CW-1:0]  x_in,
  input  logic signed [ssas_pkg::CW-1:0]  y_in,
  input  logic signed [ssas_pkg::ZW-1:0]  z_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            valid_out,
  output logic signed [ssas_pkg::CW-1:0]  x_out,
  output logic signed [ssas_pkg::CW-1:0]  y_out,
  output logic signed [ssas_pkg::ZW-1:0]  z_out,
  output logic [SIDE_W-1:0]               side_out
);

  localparam logic signed [ssas_pkg::ZW-1:0] ANGLE = ssas_pkg::atan_fine(STAGE);

  logic signed [ssas_pkg::CW-1:0] dx, dy;
  logic                           up;

  assign dx = x_in >>> STAGE;
  assign dy = y_in >>> STAGE;
  assign up = y_in > 0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= up ? x_in + dy : x_in - dy;
      y_out    <= up ? y_in - dx : y_in + dx;
      z_out    <= up ? z_in + ANGLE : z_in - ANGLE;
      side_out <= side_in;
    end
  end

endmodule

// ===== rtl/ssas_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ssas_sqrt_cell
// One digit of the restoring square root with a registered output.
// ----------------------------------------------------------------------------
module ssas_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_in,
  input  logic [ssas_pkg::RAD_W-1:0]        rad_in,
  input  logic [ssas_pkg::REM_W-1:0]        rem_in,
  input  logic [ssas_pkg::ROOT_W-1:0]       root_in,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              valid_out,
  output logic [ssas_pkg::RAD_W-1:0]        rad_out,
  output logic [ssas_pkg::REM_W-1:0]        rem_out,
  output logic [ssas_pkg::ROOT_W-1:0]       root_out,
  output logic [SIDE_W-1:0]                 side_out
);

  logic [ssas_pkg::REM_W-1:0] rem_sh, trial;
  logic                       ge;

  assign rem_sh = {rem_in[ssas_pkg::REM_W-3:0], rad_in[ssas_pkg::RAD_W-1 -: 2]};
  assign trial  = {root_in, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[ssas_pkg::RAD_W-3:0], 2'b00};
      rem_out  <= ge ? rem_sh - trial : rem_sh;
      root_out <= {root_in[ssas_pkg::ROOT_W-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

// ===== rtl/sun_sensor_angle_solver.sv =====
// ----------------------------------------------------------------------------
// sun_sensor_angle_solver
// Calibrates a two-axis sun sensor reading and solves sun elevation/azimuth.
// ----------------------------------------------------------------------------
// Fully pipelined: one reading per cycle while not halted. It has 5 front stages
// (calibrate, tilt products, rotate, square, sum), 23 square root cells,
// CORDIC_STAGES cordic cells and 2 output stages. The pipeline halts only when
// its last stage holds a result and the output register still waits to be taken.
module sun_sensor_angle_solver #(
  parameter int SENSOR_COUNT  = 4,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssas_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssas_pkg::out_t     out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int CW = ssas_pkg::CW;
  localparam int ZW = ssas_pkg::ZW;
  localparam int RW = ssas_pkg::RAD_W;
  localparam int QW = ssas_pkg::ROOT_W;
  localparam int MW = ssas_pkg::REM_W;
  localparam int SQ_SIDE = 2 + 1 + 24 + CW + CW + ZW + 1;
  localparam int EL_SIDE = 2 + 1 + 1;

  // configuration
  logic [14:0]        limit_r;
  logic signed [14:0] band_lo_r, band_hi_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= 15'd4096;
      band_lo_r <= 15'sd0;
      band_hi_r <= 15'sd5120;
    end else if (cfg_valid) begin
      case (cfg_index)
        ssas_pkg::REG_SUN_SEEN_LIMIT: limit_r   <= cfg_data;
        ssas_pkg::REG_EL_BAND_LOW:    band_lo_r <= cfg_data;
        ssas_pkg::REG_EL_BAND_HIGH:   band_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  logic adv, p1_v_r, out_valid_r;
  ssas_pkg::out_t out_data_r;

  assign adv       = ~(out_valid_r & ~out_ready & p1_v_r);
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stage 1: calibration
  logic signed [35:0] px, py;
  logic signed [36:0] xsum, ysum;
  logic [16:0]        abs_x, abs_y;
  logic               v1_in;
  logic               s1_v_r, s1_seen_r;
  logic [1:0]         s1_idx_r;
  logic signed [23:0] s1_x0_r, s1_y0_r;

  assign px    = 36'(in_data.raw_x) * 36'(ssas_pkg::GAIN_X[in_data.sensor_index]);
  assign py    = 36'(in_data.raw_y) * 36'(ssas_pkg::GAIN_Y[in_data.sensor_index]);
  assign xsum  = 37'(px) - (37'(ssas_pkg::OFFS_X[in_data.sensor_index]) <<< 12)
                 + 37'sd2048;
  assign ysum  = -37'(py) - (37'(ssas_pkg::OFFS_Y[in_data.sensor_index]) <<< 12)
                 + 37'sd2048;
  assign abs_x = in_data.raw_x[15] ? 17'(-18'(in_data.raw_x)) : 17'(in_data.raw_x);
  assign abs_y = in_data.raw_y[15] ? 17'(-18'(in_data.raw_y)) : 17'(in_data.raw_y);
  assign v1_in = in_valid & (32'(in_data.sensor_index) < SENSOR_COUNT);

  // stage 2: tilt products
  logic               s2_v_r, s2_seen_r;
  logic [1:0]         s2_idx_r;
  logic signed [39:0] s2_pc_r;
  logic signed [40:0] s2_ps_r;
  logic signed [23:0] s2_y0_r;

  // stage 3: rotated point
  logic signed [41:0] xs_w, zs_w;
  logic               s3_v_r, s3_seen_r;
  logic [1:0]         s3_idx_r;
  logic signed [23:0] s3_xs_r, s3_ys_r, s3_zs_r;

  assign xs_w = (-42'(s2_pc_r) - ssas_pkg::SEP_SIN[s2_idx_r] + 42'sd32768) >>> 16;
  assign zs_w = (-42'(s2_ps_r) + ssas_pkg::SEP_COS[s2_idx_r] + 42'sd32768) >>> 16;

  // stage 4: squares and azimuth quadrant fold
  logic signed [CW-1:0] ax, ay;
  logic signed [47:0]   sqx, sqy;
  logic                 s4_v_r, s4_seen_r, s4_zero_r;
  logic [1:0]           s4_idx_r;
  logic [RW-1:0]        s4_sqx_r, s4_sqy_r;
  logic signed [23:0]   s4_zs_r;
  logic signed [CW-1:0] s4_ax_r, s4_ay_r;
  logic signed [ZW-1:0] s4_az_r;

  assign ax  = -CW'(s3_xs_r);
  assign ay  = CW'(s3_ys_r);
  assign sqx = 48'(s3_xs_r) * 48'(s3_xs_r);
  assign sqy = 48'(s3_ys_r) * 48'(s3_ys_r);

  // stage 5: radicand
  logic                 s5_v_r;
  logic [RW-1:0]        s5_rad_r;
  logic [SQ_SIDE-1:0]   s5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= v1_in;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r  <= in_data.sensor_index;
      s1_seen_r <= (abs_x <= 17'(limit_r)) && (abs_y <= 17'(limit_r));
      s1_x0_r   <= 24'(xsum >>> 12);
      s1_y0_r   <= 24'(ysum >>> 12);

      s2_idx_r  <= s1_idx_r;
      s2_seen_r <= s1_seen_r;
      s2_pc_r   <= 40'(s1_x0_r) * 40'(ssas_pkg::TILT_COS[s1_idx_r]);
      s2_ps_r   <= 41'(s1_x0_r) * 41'(ssas_pkg::TILT_SIN[s1_idx_r]);
      s2_y0_r   <= s1_y0_r;

      s3_idx_r  <= s2_idx_r;
      s3_seen_r <= s2_seen_r;
      s3_xs_r   <= 24'(xs_w);
      s3_ys_r   <= -s2_y0_r;
      s3_zs_r   <= 24'(zs_w);

      s4_idx_r  <= s3_idx_r;
      s4_seen_r <= s3_seen_r;
      s4_sqx_r  <= RW'(sqx);
      s4_sqy_r  <= RW'(sqy);
      s4_zs_r   <= s3_zs_r;
      s4_zero_r <= (ax == '0) && (ay == '0);
      if (ax < 0) begin
        s4_ax_r <= -ax;
        s4_ay_r <= -ay;
        s4_az_r <= (ay >= 0) ? ssas_pkg::DEG180_FINE : -ssas_pkg::DEG180_FINE;
      end else begin
        s4_ax_r <= ax;
        s4_ay_r <= ay;
        s4_az_r <= '0;
      end

      s5_rad_r  <= s4_sqx_r + s4_sqy_r;
      s5_side_r <= {s4_idx_r, s4_seen_r, s4_zs_r, s4_ax_r, s4_ay_r, s4_az_r, s4_zero_r};
    end
  end

  // square root chain
  logic               sq_v    [0:QW];
  logic [RW-1:0]      sq_rad  [0:QW];
  logic [MW-1:0]      sq_rem  [0:QW];
  logic [QW-1:0]      sq_root [0:QW];
  logic [SQ_SIDE-1:0] sq_side [0:QW];

  assign sq_v[0]    = s5_v_r;
  assign sq_rad[0]  = s5_rad_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s5_side_r;

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    ssas_sqrt_cell #(.SIDE_W(SQ_SIDE)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .valid_in (sq_v[k]),
      .rad_in   (sq_rad[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .side_in  (sq_side[k]),
      .valid_out(sq_v[k+1]),
      .rad_out  (sq_rad[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .side_out (sq_side[k+1])
    );
  end

  // unpack what rode along the square root
  logic [1:0]           t_idx;
  logic                 t_seen, t_az_zero, t_el_zero;
  logic signed [23:0]   t_zs;
  logic signed [CW-1:0] t_ax, t_ay;
  logic signed [ZW-1:0] t_az;

  assign {t_idx, t_seen, t_zs, t_ax, t_ay, t_az, t_az_zero} = sq_side[QW];
  assign t_el_zero = (sq_root[QW] == '0) && (t_zs == '0);

  // elevation and azimuth cordic chains, in lockstep
  logic                 ev  [0:CORDIC_STAGES];
  logic signed [CW-1:0] ex  [0:CORDIC_STAGES];
  logic signed [CW-1:0] ey  [0:CORDIC_STAGES];
  logic signed [ZW-1:0] ez  [0:CORDIC_STAGES];
  logic [EL_SIDE-1:0]   es  [0:CORDIC_STAGES];
  logic                 av  [0:CORDIC_STAGES];
  logic signed [CW-1:0] axc [0:CORDIC_STAGES];
  logic signed [CW-1:0] ayc [0:CORDIC_STAGES];
  logic signed [ZW-1:0] azc [0:CORDIC_STAGES];
  logic [0:0]           as_ [0:CORDIC_STAGES];

  assign ev[0]  = sq_v[QW];
  assign ex[0]  = $signed({{(CW-QW){1'b0}}, sq_root[QW]});
  assign ey[0]  = CW'(t_zs);
  assign ez[0]  = '0;
  assign es[0]  = {t_idx, t_seen, t_el_zero};
  assign av[0]  = sq_v[QW];
  assign axc[0] = t_ax;
  assign ayc[0] = t_ay;
  assign azc[0] = t_az;
  assign as_[0] = t_az_zero;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ssas_cordic_cell #(.STAGE(i), .SIDE_W(EL_SIDE)) u_el (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .valid_in (ev[i]),
      .x_in     (ex[i]),
      .y_in     (ey[i]),
      .z_in     (ez[i]),
      .side_in  (es[i]),
      .valid_out(ev[i+1]),
      .x_out    (ex[i+1]),
      .y_out    (ey[i+1]),
      .z_out    (ez[i+1]),
      .side_out (es[i+1])
    );
    ssas_cordic_cell #(.STAGE(i), .SIDE_W(1)) u_az (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .valid_in (av[i]),
      .x_in     (axc[i]),
      .y_in     (ayc[i]),
      .z_in     (azc[i]),
      .side_in  (as_[i]),
      .valid_out(av[i+1]),
      .x_out    (axc[i+1]),
      .y_out    (ayc[i+1]),
      .z_out    (azc[i+1]),
      .side_out (as_[i+1])
    );
  end

  // post stage 1: round, clip, add mounting azimuth
  logic [1:0]           c_idx;
  logic                 c_seen, c_el_zero;
  logic signed [ZW-1:0] el_z, az_z;
  logic signed [16:0]   el_rnd, az_rnd;
  logic signed [14:0]   p1_el_r;
  logic signed [17:0]   p1_az_r;
  logic                 p1_seen_r;

  assign {c_idx, c_seen, c_el_zero} = es[CORDIC_STAGES];
  assign el_z   = c_el_zero ? '0 : ez[CORDIC_STAGES];
  assign az_z   = as_[CORDIC_STAGES][0] ? '0 : azc[CORDIC_STAGES];
  assign el_rnd = 17'((el_z + ZW'(128)) >>> 8);
  assign az_rnd = 17'((az_z + ZW'(128)) >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= ev[CORDIC_STAGES] & av[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (el_rnd > ssas_pkg::EL_LIMIT) begin
        p1_el_r <= 15'(ssas_pkg::EL_LIMIT);
      end else if (el_rnd < -ssas_pkg::EL_LIMIT) begin
        p1_el_r <= 15'(-ssas_pkg::EL_LIMIT);
      end else begin
        p1_el_r <= 15'(el_rnd);
      end
      p1_az_r   <= 18'(az_rnd) + ssas_pkg::MOUNT_AZ[c_idx] + ssas_pkg::DEG360_OUT;
      p1_seen_r <= c_seen;
    end
  end

  // post stage 2: wrap, classify, output register
  logic [15:0] az_wrap;
  logic        in_band;

  assign az_wrap = (p1_az_r > ssas_pkg::DEG360_OUT)
                   ? 16'(p1_az_r - ssas_pkg::DEG360_OUT) : 16'(p1_az_r);
  assign in_band = (p1_el_r >= band_lo_r) && (p1_el_r <= band_hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_v_r && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_v_r && adv) begin
      out_data_r.elevation <= p1_el_r;
      out_data_r.azimuth   <= az_wrap;
      out_data_r.sun_seen  <= p1_seen_r;
      if (!p1_seen_r) begin
        out_data_r.display_class <= ssas_pkg::CLASS_NO_SUN;
      end else if (in_band) begin
        out_data_r.display_class <= ssas_pkg::CLASS_IN_BAND;
      end else begin
        out_data_r.display_class <= ssas_pkg::CLASS_OUT_BAND;
      end
    end
  end

endmodule

// ===== tb/sv/sun_sensor_angle_solver_tb.sv =====
// ----------------------------------------------------------------------------
// sun_sensor_angle_solver_tb
// Self-checking bench for the sun sensor angle solver. Readings are driven
// in random bursts. Each accepted reading is solved by a bit-exact
// fixed-point model of calibration, tilt, CORDIC and square root. Results
// are checked in order against it under random and long output stalls,
// across several register settings.
// ----------------------------------------------------------------------------
module sun_sensor_angle_solver_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 80;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ssas_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  ssas_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  sun_sensor_angle_solver DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // calibration tables, q.16
  localparam longint GX [4] = '{329567, 317948, 331606, 329567};
  localparam longint GY [4] = '{327680, 327680, 327680, 327680};
  localparam longint OX [4] = '{5243, -21588, 3631, -15580};
  localparam longint OY [4] = '{-10302, -11454, -5543, -33001};
  localparam longint SEP [4] = '{242771, 237147, 230164, 232945};
  localparam longint TC [4] = '{25502, 24868, 25396, 25607};
  localparam longint TS [4] = '{60371, 60635, 60415, 60326};
  localparam longint MOUNT [4] = '{5760, -5760, -17280, 17280};
  localparam longint ATAN_TBL [16] = '{1474560, 870484, 459940, 233473, 117189, 58652,
                                       29333, 14667, 7334, 3667, 1833, 917, 458, 229,
                                       115, 57};

  longint seen_limit;
  longint band_low;
  longint band_high;

  ssas_pkg::out_t solved_q [$];
  int     mismatches;
  int     results_seen;
  int     readings_sent;
  int     cfg_writes;
  int     idle_cycles;
  int     burst_left;
  bit     no_gaps;
  bit     hold_req;
  int     hold_left;
  int     rx_mode;
  int     rx_left;
  int     rx_tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // atan2(y, x) in 1/32768 degree
  function automatic longint cordic_atan2(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 5898240 : -5898240;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_TBL[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic ssas_pkg::out_t solve_reading(ssas_pkg::in_t item);
    ssas_pkg::out_t res;
    int     k;
    longint rx, ry, x0, y0, xs, ys, zs, az, el, r, ax, ay;
    bit     seen;
    k  = item.sensor_index;
    rx = item.raw_x;
    ry = item.raw_y;
    x0 = round_shift(rx * GX[k] - OX[k] * 4096, 12);
    y0 = round_shift(-ry * GY[k] - OY[k] * 4096, 12);
    xs = round_shift(-x0 * TC[k] - SEP[k] * TS[k], 16);
    ys = -y0;
    zs = round_shift(-x0 * TS[k] + SEP[k] * TC[k], 16);
    az = round_shift(cordic_atan2(-xs, ys), 8);
    r  = int_sqrt(xs * xs + ys * ys);
    el = round_shift(cordic_atan2(r, zs), 8);
    if (el > 11520) el = 11520;
    if (el < -11520) el = -11520;
    az = az + MOUNT[k] + 46080;
    while (az > 46080) az = az - 46080;
    while (az < 0) az = az + 46080;
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    seen = (ax <= seen_limit) && (ay <= seen_limit);
    res.elevation = el[14:0];
    res.azimuth   = az[15:0];
    res.sun_seen  = seen;
    if (!seen) res.display_class = ssas_pkg::CLASS_NO_SUN;
    else if (el >= band_low && el <= band_high) res.display_class = ssas_pkg::CLASS_IN_BAND;
    else res.display_class = ssas_pkg::CLASS_OUT_BAND;
    return res;
  endfunction

  task automatic send_reading(input logic [1:0] idx, input logic [15:0] rx,
                              input logic [15:0] ry);
    ssas_pkg::in_t item;
    int  gap;
    item.sensor_index = idx;
    item.raw_x = rx;
    item.raw_y = ry;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if (!no_gaps) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    solved_q.push_back(solve_reading(item));
    readings_sent++;
    burst_left--;
  endtask

  task automatic wait_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (solved_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
    wait_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ssas_pkg::REG_SUN_SEEN_LIMIT: seen_limit = value;
      ssas_pkg::REG_EL_BAND_LOW:    band_low = longint'($signed(value));
      ssas_pkg::REG_EL_BAND_HIGH:   band_high = longint'($signed(value));
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    logic [15:0] rx;
    logic [15:0] ry;
    int          span;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1)) begin
        span = (seen_limit < 32767) ? int'(seen_limit) + 1 : 32767;
        rx = 16'($urandom_range(0, 2 * span) - span);
        ry = 16'($urandom_range(0, 2 * span) - span);
      end else begin
        rx = 16'($urandom);
        ry = 16'($urandom);
      end
      send_reading(2'($urandom), rx, ry);
    end
  endtask

  task automatic test_directed;
    logic [15:0] edges [6];
    edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h8001, 16'h1000, 16'hf000};
    for (int k = 0; k < 4; k++) send_reading(2'(k), 16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_reading(2'(i % 4), edges[i], edges[5 - i]);
    send_reading(2'd0, 16'h1001, 16'h0000);
    send_reading(2'd1, 16'h0000, 16'hefff);
    send_reading(2'd2, 16'h7fff, 16'h7fff);
    send_reading(2'd3, 16'h8000, 16'h8000);
    send_reading(2'd0, 16'hd000, 16'h0000);
    send_reading(2'd1, 16'h3000, 16'hc000);
  endtask

  task automatic test_limit_extremes;
    write_reg(ssas_pkg::REG_SUN_SEEN_LIMIT, 15'd0);
    send_reading(2'd0, 16'h0000, 16'h0000);
    send_reading(2'd1, 16'h0001, 16'h0000);
    send_random(150);
    write_reg(ssas_pkg::REG_SUN_SEEN_LIMIT, 15'h7fff);
    send_reading(2'd2, 16'h7fff, 16'h8001);
    send_reading(2'd3, 16'h8000, 16'h0000);
    send_random(250);
  endtask

  task automatic test_band_extremes;
    write_reg(ssas_pkg::REG_EL_BAND_LOW, 15'(-11520));
    write_reg(ssas_pkg::REG_EL_BAND_HIGH, 15'(11520));
    send_random(250);
    write_reg(ssas_pkg::REG_EL_BAND_LOW, 15'(11520));
    write_reg(ssas_pkg::REG_EL_BAND_HIGH, 15'(-11520));
    send_random(150);
    write_reg(ssas_pkg::REG_EL_BAND_LOW, 15'(-3000));
    write_reg(ssas_pkg::REG_EL_BAND_HIGH, 15'(2000));
    write_reg(ssas_pkg::REG_SUN_SEEN_LIMIT, 15'd20000);
    send_random(300);
  endtask

  task automatic test_backpressure;
    hold_req = 1'b1;
    no_gaps = 1'b1;
    send_random(200);
    no_gaps = 1'b0;
    wait_results();
    send_random(150);
  endtask

  task automatic test_random_settings;
    for (int p = 0; p < 3; p++) begin
      write_reg(ssas_pkg::REG_SUN_SEEN_LIMIT, 15'($urandom));
      write_reg(ssas_pkg::REG_EL_BAND_LOW, 15'($urandom_range(0, 23040) - 11520));
      write_reg(ssas_pkg::REG_EL_BAND_HIGH, 15'($urandom_range(0, 23040) - 11520));
      send_random(100);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        default: out_ready <= (rx_tick % 5) < 2;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (solved_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", out_data);
      end else begin
        ssas_pkg::out_t want;
        want = solved_q.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp el %0d az %0d seen %0b cls %0d, ",
                      "got el %0d az %0d seen %0b cls %0d"},
                     $signed(want.elevation), want.azimuth, want.sun_seen,
                     want.display_class, $signed(out_data.elevation), out_data.azimuth,
                     out_data.sun_seen, out_data.display_class);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ssas_pkg::REG_SUN_SEEN_LIMIT;
    cfg_data = '0;
    seen_limit = 4096;
    band_low = 0;
    band_high = 5120;
    mismatches = 0;
    results_seen = 0;
    readings_sent = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    rx_mode = 0;
    rx_left = 0;
    rx_tick = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    send_random(30);
    test_limit_extremes();
    test_band_extremes();
    test_backpressure();
    test_random_settings();

    wait_results();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d readings, %0d results, %0d register writes", readings_sent,
             results_seen, cfg_writes);
    $display("limit and band extremes, long output stall and drained pauses included");
    if (mismatches == 0 && solved_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, solved_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
